[src/vpc_pkg.sv]
// shared types and constants for the vertical popcount tile prefix block
package vpc_pkg;

	localparam int unsigned NBITS       = 32;
	localparam int unsigned POS_W       = 5;
	localparam int unsigned CNT_W       = 32;
	localparam int unsigned GROUP_W     = 8;
	localparam int unsigned TILE_W      = 10;
	localparam int unsigned ROW_W       = 8;
	localparam int unsigned LOG2_W      = 4;
	localparam int unsigned SIZE_W      = 9;

	// group labels wrap at MAX_GROUPS, which covers the whole 8-bit field
	localparam int unsigned MAX_GROUPS  = 256;
	localparam int unsigned MAX_TILES   = 1024;
	localparam int unsigned TILE_CAP_I  = (MAX_TILES - 1 > 1023) ? 1023 : MAX_TILES - 1;
	localparam logic [TILE_W-1:0] TILE_CAP = TILE_W'(TILE_CAP_I);

	localparam logic [LOG2_W-1:0] TILE_LOG2_RESET = 4'd7;
	localparam logic [LOG2_W-1:0] TILE_LOG2_MIN   = 4'd3;
	localparam logic [LOG2_W-1:0] TILE_LOG2_MAX   = 4'd8;

	localparam logic KIND_PREFIX = 1'b0;
	localparam logic KIND_TOTAL  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRE,
		ST_TOT
	} vpc_state_t;

	// per-cycle command broadcast to every counter cell
	typedef struct packed {
		logic add;
		logic clear;
		logic load_pre;
		logic load_tot;
		logic shift;
	} cell_cmd_t;

endpackage

[src/vpc_ifs.sv]
// valid/ready channel interfaces for row words and results
interface vpc_row_if;
	import vpc_pkg::*;
	logic               valid;
	logic               ready;
	logic [NBITS-1:0]   row_bits;
	logic [GROUP_W-1:0] column_group;
	logic               last_row;

	modport source (output valid, row_bits, column_group, last_row, input ready);
	modport sink   (input valid, row_bits, column_group, last_row, output ready);
endinterface

interface vpc_res_if;
	import vpc_pkg::*;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [GROUP_W-1:0] group_out;
	logic [TILE_W-1:0]  tile_number;
	logic [POS_W-1:0]   bit_position;
	logic [CNT_W-1:0]   count;
	logic               run_end;

	modport source (output valid, result_kind, group_out, tile_number, bit_position, count,
		run_end, input ready);
	modport sink   (input valid, result_kind, group_out, tile_number, bit_position, count,
		run_end, output ready);
endinterface

[src/vpc_cell.sv]
// one bit-position counter with a snapshot stage that shifts toward the output
module vpc_cell
	import vpc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_cmd_t        cmd,
	input  logic             bit_in,
	input  logic [CNT_W-1:0] snap_in,
	output logic [CNT_W-1:0] snap_out
);

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] snap_q;
	logic [CNT_W-1:0] cnt_sum;

	assign cnt_sum  = cnt_q + CNT_W'(cmd.add & bit_in);
	assign snap_out = snap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clear) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_sum;
		end
	end

	// prefix takes the count before this row, totals take it after
	always_ff @(posedge clk) begin
		if (cmd.load_pre) begin
			snap_q <= cnt_q;
		end else if (cmd.load_tot) begin
			snap_q <= cnt_sum;
		end else if (cmd.shift) begin
			snap_q <= snap_in;
		end
	end

endmodule

[src/vpc_ctrl.sv]
// sequencer: tile tracking, drain control and result labels
module vpc_ctrl
	import vpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [LOG2_W-1:0]  cfg_wdata,
	input  logic               in_valid,
	input  logic [GROUP_W-1:0] in_group,
	input  logic               in_last,
	output logic               in_ready,
	input  logic               out_ready,
	output logic               out_valid,
	output logic               out_kind,
	output logic [GROUP_W-1:0] out_group,
	output logic [TILE_W-1:0]  out_tile,
	output logic [POS_W-1:0]   out_pos,
	output logic               out_end,
	output cell_cmd_t          cmd
);

	vpc_state_t         state_q, state_nxt;
	logic [LOG2_W-1:0]  tile_log2_q;
	logic [ROW_W-1:0]   row_in_tile_q;
	logic [TILE_W-1:0]  tile_index_q;
	logic [TILE_W-1:0]  tile_out_q;
	logic [GROUP_W-1:0] group_q;
	logic               last_q;
	logic [POS_W-1:0]   beat_q;

	logic               acc;
	logic               fire;
	logic               beat_last;
	logic               prefix;
	logic [LOG2_W-1:0]  tl_clamp;
	logic [SIZE_W-1:0]  rows_per_tile;
	logic [ROW_W-1:0]   row_inc;
	logic               tile_end;

	assign acc       = in_valid && in_ready;
	assign fire      = out_valid && out_ready;
	assign beat_last = (beat_q == POS_W'(NBITS - 1));
	assign prefix    = (row_in_tile_q == '0);

	always_comb begin
		if (tile_log2_q < TILE_LOG2_MIN) begin
			tl_clamp = TILE_LOG2_MIN;
		end else if (tile_log2_q > TILE_LOG2_MAX) begin
			tl_clamp = TILE_LOG2_MAX;
		end else begin
			tl_clamp = tile_log2_q;
		end
	end

	assign rows_per_tile = SIZE_W'(1) << tl_clamp;
	assign row_inc       = row_in_tile_q + ROW_W'(1);
	// an 8-bit wrap also closes the tile
	assign tile_end      = (row_inc == '0) || ({1'b0, row_inc} >= rows_per_tile);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (prefix) begin
						state_nxt = ST_PRE;
					end else if (in_last) begin
						state_nxt = ST_TOT;
					end
				end
			end
			ST_PRE: begin
				if (fire && beat_last) begin
					state_nxt = last_q ? ST_TOT : ST_IDLE;
				end
			end
			ST_TOT: begin
				if (fire && beat_last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		out_valid    = (state_q == ST_PRE) || (state_q == ST_TOT);
		out_kind     = (state_q == ST_TOT) ? KIND_TOTAL : KIND_PREFIX;
		out_group    = group_q;
		out_tile     = (state_q == ST_TOT) ? '0 : tile_out_q;
		out_pos      = beat_q;
		out_end      = beat_last && ((state_q == ST_TOT) || !last_q);
		cmd.add      = acc;
		cmd.load_pre = acc && prefix;
		cmd.load_tot = (acc && !prefix && in_last) ||
			((state_q == ST_PRE) && fire && beat_last && last_q);
		cmd.clear    = cmd.load_tot;
		cmd.shift    = fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			tile_log2_q   <= TILE_LOG2_RESET;
			row_in_tile_q <= '0;
			tile_index_q  <= '0;
			beat_q        <= '0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				tile_log2_q <= cfg_wdata;
			end
			if (fire) begin
				beat_q <= beat_q + POS_W'(1);
			end
			if (acc) begin
				if (in_last) begin
					row_in_tile_q <= '0;
					tile_index_q  <= '0;
				end else if (tile_end) begin
					row_in_tile_q <= '0;
					if (tile_index_q < TILE_CAP) begin
						tile_index_q <= tile_index_q + TILE_W'(1);
					end
				end else begin
					row_in_tile_q <= row_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			group_q    <= in_group;
			last_q     <= in_last;
			tile_out_q <= tile_index_q;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while results pending");

	a_beat_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (beat_q == '0))
		else $error("beat counter not aligned at idle");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_last) |=> (row_in_tile_q == '0) && (tile_index_q == '0))
		else $error("tile state not cleared after last row");

	a_pre_to_tot: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_PRE) && fire && beat_last && last_q) |=> (state_q == ST_TOT))
		else $error("totals missing after prefix drain");

	a_tile_cap: assert property (@(posedge clk) disable iff (!arst_n)
		tile_index_q <= TILE_CAP)
		else $error("tile index beyond cap");

endmodule

[src/vertical_popcount_tile_prefix.sv]
// latency: the first result beat is offered the cycle after its row beat is taken
// a row that opens a tile yields 32 prefix beats, a last row 32 total beats (64 if both)
// an item's result beats leave one per cycle while results.ready is high; a new row is
// taken only after the final result beat, since the snapshot chain drains serially
// reset clears all 32 counters, the row and tile position, and sets tile_log2 to 7
module vertical_popcount_tile_prefix
	import vpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [LOG2_W-1:0] cfg_wdata,
	vpc_row_if.sink           rows,
	vpc_res_if.source         results
);

	cell_cmd_t        cmd;
	logic [CNT_W-1:0] snap_chain [NBITS+1];

	vpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (rows.valid),
		.in_group  (rows.column_group),
		.in_last   (rows.last_row),
		.in_ready  (rows.ready),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.out_kind  (results.result_kind),
		.out_group (results.group_out),
		.out_tile  (results.tile_number),
		.out_pos   (results.bit_position),
		.out_end   (results.run_end),
		.cmd       (cmd)
	);

	// the far end of the chain feeds zeros
	assign snap_chain[NBITS] = '0;

	for (genvar i = 0; i < NBITS; i++) begin : g_cell
		vpc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.bit_in   (rows.row_bits[i]),
			.snap_in  (snap_chain[i+1]),
			.snap_out (snap_chain[i])
		);
	end

	assign results.count = snap_chain[0];

endmodule

[verif/vpc_beat_checker.sv]
`timescale 1ns / 100ps
// beat checker: predicts result beats from accepted row beats and compares them in order
module vpc_beat_checker
	import vpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [LOG2_W-1:0] cfg_wdata,
	vpc_row_if                rows,
	vpc_res_if                results,
	output int                errors,
	output int                pending,
	output int                beats_checked
);

	typedef struct packed {
		logic               kind;
		logic [GROUP_W-1:0] grp;
		logic [TILE_W-1:0]  tile;
		logic [POS_W-1:0]   pos;
		logic [CNT_W-1:0]   cnt;
		logic               fin;
	} res_beat_t;

	logic [CNT_W-1:0]  tally [NBITS];
	logic [ROW_W-1:0]  row_pos;
	logic [TILE_W-1:0] tile_ctr;
	logic [LOG2_W-1:0] log2_cfg;
	res_beat_t         expected_beats [$];

	task automatic report_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (errors < 100)
			$display("mismatch at %0t ns: %s expected 0x%0h got 0x%0h", $time, what, want, got);
		errors++;
	endtask

	// one row beat: prefix set if it opens a tile, count it, totals if it closes the run
	task automatic count_row(input logic [NBITS-1:0] bits, input logic [GROUP_W-1:0] group_in,
		input logic fin_row);
		logic [LOG2_W-1:0] eff;
		logic [SIZE_W-1:0] span;
		res_beat_t         b;
		eff = (log2_cfg < TILE_LOG2_MIN) ? TILE_LOG2_MIN :
			((log2_cfg > TILE_LOG2_MAX) ? TILE_LOG2_MAX : log2_cfg);
		span = SIZE_W'(1) << eff;
		if (row_pos == '0) begin
			for (int i = 0; i < NBITS; i++) begin
				b = '{kind: KIND_PREFIX, grp: group_in, tile: tile_ctr, pos: POS_W'(i),
					cnt: tally[i], fin: (i == NBITS - 1) && !fin_row};
				expected_beats.push_back(b);
			end
		end
		for (int i = 0; i < NBITS; i++)
			tally[i] = tally[i] + CNT_W'(bits[i]);
		row_pos = row_pos + ROW_W'(1);
		// tile closes on reaching the current size, also after a size change mid-tile
		if (row_pos == '0 || SIZE_W'(row_pos) >= span) begin
			row_pos = '0;
			if (tile_ctr < TILE_CAP)
				tile_ctr = tile_ctr + TILE_W'(1);
		end
		if (fin_row) begin
			for (int i = 0; i < NBITS; i++) begin
				b = '{kind: KIND_TOTAL, grp: group_in, tile: '0, pos: POS_W'(i),
					cnt: tally[i], fin: (i == NBITS - 1)};
				expected_beats.push_back(b);
			end
			for (int i = 0; i < NBITS; i++)
				tally[i] = '0;
			row_pos = '0;
			tile_ctr = '0;
		end
	endtask

	task automatic check_beat();
		res_beat_t want;
		if (expected_beats.size() == 0) begin
			report_mismatch("result beat with nothing expected, count", '0, results.count);
		end else begin
			want = expected_beats.pop_front();
			if (results.result_kind !== want.kind)
				report_mismatch("result_kind", 32'(want.kind), 32'(results.result_kind));
			if (results.group_out !== want.grp)
				report_mismatch("group_out", 32'(want.grp), 32'(results.group_out));
			if (results.tile_number !== want.tile)
				report_mismatch("tile_number", 32'(want.tile), 32'(results.tile_number));
			if (results.bit_position !== want.pos)
				report_mismatch("bit_position", 32'(want.pos), 32'(results.bit_position));
			if (results.count !== want.cnt)
				report_mismatch("count", want.cnt, results.count);
			if (results.run_end !== want.fin)
				report_mismatch("run_end", 32'(want.fin), 32'(results.run_end));
			beats_checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NBITS; i++)
				tally[i] = '0;
			row_pos = '0;
			tile_ctr = '0;
			log2_cfg = TILE_LOG2_RESET;
			expected_beats.delete();
		end else begin
			if (cfg_we)
				log2_cfg = cfg_wdata;
			if (rows.valid && rows.ready)
				count_row(rows.row_bits, rows.column_group, rows.last_row);
			if (results.valid && results.ready)
				check_beat();
		end
		pending = expected_beats.size();
	end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// testbench top: reset, row stimulus in phases, tile size writes and the verdict
module testbench;
	import vpc_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [LOG2_W-1:0] cfg_wdata;
	int                errors;
	int                pending;
	int                beats_checked;
	int                idle_pct;
	int                stall_pct;
	int                rows_sent;
	int                cfg_writes;

	vpc_row_if row_ch ();
	vpc_res_if res_ch ();

	vertical_popcount_tile_prefix dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rows      (row_ch),
		.results   (res_ch)
	);

	vpc_beat_checker beat_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.rows          (row_ch),
		.results       (res_ch),
		.errors        (errors),
		.pending       (pending),
		.beats_checked (beats_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// result side back-pressure
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	function automatic logic [NBITS-1:0] pick_bits();
		case ($urandom_range(0, 5))
			0: pick_bits = '0;
			1: pick_bits = '1;
			2: pick_bits = NBITS'(1) << $urandom_range(0, NBITS - 1);
			3: pick_bits = ~(NBITS'(1) << $urandom_range(0, NBITS - 1));
			default: pick_bits = $urandom();
		endcase
	endfunction

	// called and returns at a falling edge; valid stays high into the next call
	task automatic send_row(input logic [NBITS-1:0] bits, input logic [GROUP_W-1:0] grp,
		input logic fin);
		while ($urandom_range(0, 99) < idle_pct) begin
			row_ch.valid <= 1'b0;
			@(negedge clk);
		end
		row_ch.valid <= 1'b1;
		row_ch.row_bits <= bits;
		row_ch.column_group <= grp;
		row_ch.last_row <= fin;
		@(posedge clk);
		while (!row_ch.ready)
			@(posedge clk);
		@(negedge clk);
		rows_sent++;
	endtask

	// hold rows back until every expected beat is in, then let the block go quiet
	task automatic settle();
		row_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_tile_log2(input logic [LOG2_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
	endtask

	task automatic run_rows(input int n, input logic [GROUP_W-1:0] grp);
		for (int k = 0; k < n; k++)
			send_row(pick_bits(), grp, k == n - 1);
	endtask

	task automatic random_phase(input int n_rows, input int idle, input int stall,
		input logic [LOG2_W-1:0] log2v);
		int                 left;
		int                 seq_len;
		logic [GROUP_W-1:0] grp;
		logic               fin;
		write_tile_log2(log2v);
		idle_pct = idle;
		stall_pct = stall;
		left = n_rows;
		while (left > 0) begin
			seq_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 120) :
				$urandom_range(1, 16);
			grp = GROUP_W'($urandom_range(0, 255));
			for (int k = 0; k < seq_len && left > 0; k++) begin
				// label change without a last row
				if ($urandom_range(0, 19) == 0)
					grp = GROUP_W'($urandom_range(0, 255));
				fin = (k == seq_len - 1) ? ($urandom_range(0, 9) != 0) :
					($urandom_range(0, 39) == 0);
				send_row(pick_bits(), grp, fin);
				left--;
				if ($urandom_range(0, 49) == 0)
					settle();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		row_ch.valid = 1'b0;
		row_ch.row_bits = '0;
		row_ch.column_group = '0;
		row_ch.last_row = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		rows_sent = 0;
		cfg_writes = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes at the reset tile size, group change mid run
		send_row(32'h0000_0000, 8'd0, 1'b0);
		send_row(32'hFFFF_FFFF, 8'd255, 1'b0);
		send_row(32'h1111_1111, 8'h5A, 1'b0);
		send_row(32'h0F0F_0F0F, 8'hA5, 1'b1);
		send_row(32'hFFFF_FFFF, 8'd1, 1'b1);
		send_row(32'h8000_0001, 8'd128, 1'b1);
		settle();

		// size below range acts as the smallest tile
		write_tile_log2(4'd0);
		run_rows(9, 8'd7);

		// size above range acts as the largest, then shrink mid-tile
		write_tile_log2(4'd15);
		for (int k = 0; k < 8; k++)
			send_row(pick_bits(), 8'd200, 1'b0);
		write_tile_log2(TILE_LOG2_MIN);
		send_row(32'hAAAA_5555, 8'd200, 1'b0);
		send_row(32'h5555_AAAA, 8'd200, 1'b1);

		// a full 256-row tile, where the row position wraps, and the next one opened
		write_tile_log2(TILE_LOG2_MAX);
		run_rows(258, 8'd33);

		random_phase(22, 0, 0, 4'($urandom_range(0, 6)));
		random_phase(22, 74, 0, 4'($urandom_range(0, 6)));
		random_phase(22, 0, 74, 4'($urandom_range(0, 6)));
		random_phase(24, 12, 12, 4'($urandom_range(0, 15)));
		settle();

		$display("sent %0d row beats, checked %0d result beats, %0d tile size writes",
			rows_sent, beats_checked, cfg_writes);
		$display("covered prefix and total beats, tiles of 8 to 256 rows, mid-tile resize");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
